### rtl/caf_pkg.sv
package caf_pkg;

    // Operation codes carried in the operation field.
    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_ADC   = 6'd1;
    localparam logic [5:0] OP_SUB   = 6'd2;
    localparam logic [5:0] OP_SBC   = 6'd3;
    localparam logic [5:0] OP_AND   = 6'd4;
    localparam logic [5:0] OP_XOR   = 6'd5;
    localparam logic [5:0] OP_OR    = 6'd6;
    localparam logic [5:0] OP_CP    = 6'd7;
    localparam logic [5:0] OP_INC   = 6'd8;
    localparam logic [5:0] OP_DEC   = 6'd9;
    localparam logic [5:0] OP_RLC   = 6'd10;
    localparam logic [5:0] OP_RRC   = 6'd11;
    localparam logic [5:0] OP_RL    = 6'd12;
    localparam logic [5:0] OP_RR    = 6'd13;
    localparam logic [5:0] OP_SLA   = 6'd14;
    localparam logic [5:0] OP_SRA   = 6'd15;
    localparam logic [5:0] OP_SWAP  = 6'd16;
    localparam logic [5:0] OP_SRL   = 6'd17;
    localparam logic [5:0] OP_RLCA  = 6'd18;
    localparam logic [5:0] OP_RRCA  = 6'd19;
    localparam logic [5:0] OP_RLA   = 6'd20;
    localparam logic [5:0] OP_RRA   = 6'd21;
    localparam logic [5:0] OP_BIT   = 6'd22;
    localparam logic [5:0] OP_RES   = 6'd23;
    localparam logic [5:0] OP_SET   = 6'd24;
    localparam logic [5:0] OP_DAA   = 6'd25;
    localparam logic [5:0] OP_CPL   = 6'd26;
    localparam logic [5:0] OP_SCF   = 6'd27;
    localparam logic [5:0] OP_CCF   = 6'd28;
    localparam logic [5:0] OP_ADD16 = 6'd29;
    localparam logic [5:0] OP_ADDSP = 6'd30;
    localparam logic [5:0] OP_INC16 = 6'd31;
    localparam logic [5:0] OP_DEC16 = 6'd32;

    localparam logic [11:0] HALF16_MASK = 12'hFFF;
    localparam logic [15:0] DAA_LOW     = 16'h0006;
    localparam logic [15:0] DAA_HIGH    = 16'h0060;
    localparam logic [15:0] DAA_HI_LIM  = 16'h00A0;
    localparam logic [3:0]  DAA_LO_LIM  = 4'hA;
    localparam logic [15:0] BYTE_MASK   = 16'h00FF;

    typedef struct packed {
        logic [5:0]  operation;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_pos;
        logic        zero_in;
        logic        subtract_in;
        logic        half_in;
        logic        carry_in;
    } alu_in_t;

    typedef struct packed {
        logic [15:0] result;
        logic        result_valid;
        logic        zero_out;
        logic        subtract_out;
        logic        half_out;
        logic        carry_out;
    } alu_out_t;

endpackage

### rtl/caf_alu.sv
module caf_alu (
    input  caf_pkg::alu_in_t  item,
    output caf_pkg::alu_out_t outcome
);
    import caf_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  mask;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  sum_nib;
    logic [8:0]  diff9;
    logic [4:0]  diff_nib;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sext_b;

    assign a       = item.operand_a[7:0];
    assign b       = item.operand_b[7:0];
    assign mask    = 8'd1 << item.bit_pos;
    assign cin     = ((item.operation == OP_ADC) || (item.operation == OP_SBC)) ?
                     item.carry_in : 1'b0;
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign sum_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    assign diff_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
    assign sum17   = {1'b0, item.operand_a} + {1'b0, item.operand_b};
    assign sum13   = {1'b0, item.operand_a[11:0] & HALF16_MASK}
                   + {1'b0, item.operand_b[11:0] & HALF16_MASK};
    assign sext_b  = {{8{b[7]}}, b};

    always_comb
    begin
        logic [15:0] res;
        logic [15:0] t;
        logic        valid;
        logic        z;
        logic        n;
        logic        h;
        logic        c;

        res   = '0;
        t     = {8'd0, a};
        valid = 1'b1;
        z     = item.zero_in;
        n     = item.subtract_in;
        h     = item.half_in;
        c     = item.carry_in;

        unique case (item.operation) inside
            OP_ADD, OP_ADC:
            begin
                res = {8'd0, sum9[7:0]};
                h   = sum_nib[4];
                c   = sum9[8];
                n   = 1'b0;
                z   = (sum9[7:0] == 8'd0);
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                res = {8'd0, diff9[7:0]};
                h   = diff_nib[4];
                c   = diff9[8];
                n   = 1'b1;
                z   = (diff9[7:0] == 8'd0);
                if (item.operation == OP_CP)
                begin
                    res   = '0;
                    valid = 1'b0;
                end
            end
            OP_AND, OP_XOR, OP_OR:
            begin
                if (item.operation == OP_AND)
                    res = {8'd0, a & b};
                else if (item.operation == OP_XOR)
                    res = {8'd0, a ^ b};
                else
                    res = {8'd0, a | b};
                h = (item.operation == OP_AND);
                c = 1'b0;
                n = 1'b0;
                z = (res == 16'd0);
            end
            OP_INC:
            begin
                res = {8'd0, a + 8'd1};
                h   = (res[3:0] == 4'h0);
                n   = 1'b0;
                z   = (res == 16'd0);
            end
            OP_DEC:
            begin
                res = {8'd0, a - 8'd1};
                h   = (res[3:0] == 4'hF);
                n   = 1'b1;
                z   = (res == 16'd0);
            end
            OP_RLC, OP_RLCA:
            begin
                res = {8'd0, a[6:0], a[7]};
                c   = a[7];
            end
            OP_RRC, OP_RRCA:
            begin
                res = {8'd0, a[0], a[7:1]};
                c   = a[0];
            end
            OP_RL, OP_RLA:
            begin
                res = {8'd0, a[6:0], item.carry_in};
                c   = a[7];
            end
            OP_RR, OP_RRA:
            begin
                res = {8'd0, item.carry_in, a[7:1]};
                c   = a[0];
            end
            OP_SLA:
            begin
                res = {8'd0, a[6:0], 1'b0};
                c   = a[7];
            end
            OP_SRA:
            begin
                res = {8'd0, a[7], a[7:1]};
                c   = a[0];
            end
            OP_SWAP:
            begin
                res = {8'd0, a[3:0], a[7:4]};
                c   = 1'b0;
            end
            OP_SRL:
            begin
                res = {8'd0, 1'b0, a[7:1]};
                c   = a[0];
            end
            OP_BIT:
            begin
                z     = ((a & mask) == 8'd0);
                h     = 1'b1;
                n     = 1'b0;
                valid = 1'b0;
            end
            OP_RES:
                res = {8'd0, a & ~mask};
            OP_SET:
                res = {8'd0, a | mask};
            OP_DAA:
            begin
                if (item.subtract_in)
                begin
                    if (item.half_in)
                    begin
                        t = t - DAA_LOW;
                        if (!item.carry_in)
                            t = t & BYTE_MASK;
                    end
                    if (item.carry_in)
                        t = t - DAA_HIGH;
                end
                else
                begin
                    if (item.half_in || (t[3:0] >= DAA_LO_LIM))
                        t = t + DAA_LOW;
                    if (item.carry_in || (t >= DAA_HI_LIM))
                        t = t + DAA_HIGH;
                end
                res = {8'd0, t[7:0]};
                c   = item.carry_in | (t > BYTE_MASK);
                h   = 1'b0;
                z   = (t[7:0] == 8'd0);
            end
            OP_CPL:
            begin
                res = {8'd0, ~a};
                h   = 1'b1;
                n   = 1'b1;
            end
            OP_SCF:
            begin
                c     = 1'b1;
                h     = 1'b0;
                n     = 1'b0;
                valid = 1'b0;
            end
            OP_CCF:
            begin
                c     = ~item.carry_in;
                h     = 1'b0;
                n     = 1'b0;
                valid = 1'b0;
            end
            OP_ADD16:
            begin
                res = sum17[15:0];
                h   = sum13[12];
                c   = sum17[16];
                n   = 1'b0;
            end
            OP_ADDSP:
            begin
                res = item.operand_a + sext_b;
                c   = sum9[8];
                h   = sum_nib[4];
                n   = 1'b0;
                z   = 1'b0;
            end
            OP_INC16:
                res = item.operand_a + 16'd1;
            OP_DEC16:
                res = item.operand_a - 16'd1;
            default:
            begin
                res   = '0;
                valid = 1'b0;
            end
        endcase

        // CB-prefixed rotates and shifts set zero from the result; the
        // accumulator forms always clear it.
        if ((item.operation >= OP_RLC) && (item.operation <= OP_SRL))
        begin
            h = 1'b0;
            n = 1'b0;
            z = (res == 16'd0);
        end
        else if ((item.operation >= OP_RLCA) && (item.operation <= OP_RRA))
        begin
            h = 1'b0;
            n = 1'b0;
            z = 1'b0;
        end

        outcome.result       = res;
        outcome.result_valid = valid;
        outcome.zero_out     = z;
        outcome.subtract_out = n;
        outcome.half_out     = h;
        outcome.carry_out    = c;
    end

endmodule

### rtl/cpu_alu_with_flags_top.sv
// Flag-producing ALU of an 8-bit CPU.
// The operation channel (op_valid, op_ready, op_data) carries one transaction
// per operation: the operation code, two 16-bit operands, a bit index and the
// four incoming flags. The result channel (res_valid, res_ready, res_data)
// returns one transaction per operation: the result, whether it is to be
// stored, and the four new flags. Both channels complete a transaction on a
// rising edge where valid and ready are both high.
// An accepted operation is registered in the input stage, passes through the
// ALU and lands in the result register, where res_valid rises. Throughput is
// one operation per cycle while the receiver keeps res_ready high, set by the
// input register and the result register, each of which can be refilled in
// the cycle it is emptied.
// When the receiver stalls, the result register holds its transaction; the
// input stage then holds one more, and op_ready falls only once both stages
// are full. Reset empties both stages; no transaction is lost or invented.
module cpu_alu_with_flags_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_ready,
    input  caf_pkg::alu_in_t  op_data,
    output logic              res_valid,
    input  logic              res_ready,
    output caf_pkg::alu_out_t res_data
);
    import caf_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_in_t  s1_data_reg;
    logic     s2_valid_reg;
    logic     s2_valid_next;
    alu_out_t s2_data_reg;
    alu_out_t alu_result;
    logic     s1_ready;
    logic     s2_ready;

    // Each stage can take a new transaction when it is empty or when its
    // contents leave in the same cycle.
    assign s2_ready = !s2_valid_reg || res_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign op_ready = s1_ready;

    assign s1_valid_next = s1_ready ? op_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    caf_alu u_alu (
        .item    (s1_data_reg),
        .outcome (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers load only when their stage advances.
    always_ff @(posedge clk)
    begin
        if (op_valid && s1_ready)
            s1_data_reg <= op_data;
        if (s1_valid_reg && s2_ready)
            s2_data_reg <= alu_result;
    end

    assign res_valid = s2_valid_reg;
    assign res_data  = s2_data_reg;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && op_ready) |=> s1_valid_reg)
        else $error("accepted operation did not reach the input stage");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("input stage lost its operation during a stall");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> s2_valid_reg)
        else $error("operation did not advance into the result register");

    a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !res_data.result_valid) |-> (res_data.result == 16'd0))
        else $error("non-storing operation produced a non-zero result");

endmodule

### test/cpu_alu_with_flags_top_tb.sv
`timescale 1ns / 100ps

module cpu_alu_with_flags_top_tb;

    import caf_pkg::*;

    // Number of random operations queued after the directed ones.
    localparam int RANDOM_OPS = 1850;

    // Watchdog limit in clock cycles. A correct run stays far below it even
    // with both sides idling, so this leaves a wide margin.
    localparam int CYCLE_LIMIT = 200000;

    // Cycles allowed after the last result for any stray transaction to show.
    localparam int DRAIN_CYCLES = 8;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     op_valid  = 1'b0;
    logic     op_ready;
    alu_in_t  op_data   = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    alu_out_t res_data;

    // Operations waiting to be offered, and outcomes waiting to be returned.
    alu_in_t  queued_ops[$];
    alu_out_t due_results[$];

    int       ops_accepted = 0;
    int       total_ops    = 0;
    int       failures     = 0;
    int       cycle_count  = 0;
    alu_out_t want_res;

    // While this is high neither side idles, so the block runs back to back
    // for 400 transactions.
    logic steady;
    assign steady = (ops_accepted >= 700) && (ops_accepted < 1100);

    cpu_alu_with_flags_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Expected outcome of one operation. Eight-bit operations work on the
    // low bytes of the operands; flags an operation does not touch pass
    // straight through from the incoming ones.
    function automatic alu_out_t alu_outcome(alu_in_t op);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  t8;
        logic [7:0]  bit_mask;
        logic [8:0]  nine;
        logic [4:0]  nib;
        logic [12:0] twelve;
        logic [16:0] wide;
        logic [15:0] dt;
        logic [15:0] res;
        logic        cin;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
        logic        valid;
        alu_out_t    r;

        a        = op.operand_a[7:0];
        b        = op.operand_b[7:0];
        bit_mask = 8'h01 << op.bit_pos;
        z        = op.zero_in;
        n        = op.subtract_in;
        h        = op.half_in;
        c        = op.carry_in;
        res      = 16'h0000;
        valid    = 1'b1;

        case (op.operation)
            OP_ADD, OP_ADC:
            begin
                cin  = (op.operation == OP_ADC) ? c : 1'b0;
                nine = {1'b0, a} + {1'b0, b} + cin;
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + cin;
                h    = nib[4];
                c    = nine[8];
                n    = 1'b0;
                res  = {8'h00, nine[7:0]};
                z    = (nine[7:0] == 8'h00);
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                cin = (op.operation == OP_SBC) ? c : 1'b0;
                h   = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + cin);
                c   = {1'b0, a} < ({1'b0, b} + cin);
                t8  = a - b - cin;
                n   = 1'b1;
                z   = (t8 == 8'h00);
                res = {8'h00, t8};
                // Compare only sets the flags.
                if (op.operation == OP_CP)
                begin
                    res   = 16'h0000;
                    valid = 1'b0;
                end
            end
            OP_AND, OP_XOR, OP_OR:
            begin
                if (op.operation == OP_AND)
                    t8 = a & b;
                else if (op.operation == OP_XOR)
                    t8 = a ^ b;
                else
                    t8 = a | b;
                h   = (op.operation == OP_AND);
                c   = 1'b0;
                n   = 1'b0;
                z   = (t8 == 8'h00);
                res = {8'h00, t8};
            end
            OP_INC:
            begin
                t8  = a + 8'h01;
                h   = (t8[3:0] == 4'h0);
                n   = 1'b0;
                z   = (t8 == 8'h00);
                res = {8'h00, t8};
            end
            OP_DEC:
            begin
                t8  = a - 8'h01;
                h   = (t8[3:0] == 4'hF);
                n   = 1'b1;
                z   = (t8 == 8'h00);
                res = {8'h00, t8};
            end
            OP_RLC, OP_RLCA:
            begin
                res = {8'h00, a[6:0], a[7]};
                c   = a[7];
            end
            OP_RRC, OP_RRCA:
            begin
                res = {8'h00, a[0], a[7:1]};
                c   = a[0];
            end
            OP_RL, OP_RLA:
            begin
                res = {8'h00, a[6:0], c};
                c   = a[7];
            end
            OP_RR, OP_RRA:
            begin
                res = {8'h00, c, a[7:1]};
                c   = a[0];
            end
            OP_SLA:
            begin
                res = {8'h00, a[6:0], 1'b0};
                c   = a[7];
            end
            OP_SRA:
            begin
                res = {8'h00, a[7], a[7:1]};
                c   = a[0];
            end
            OP_SWAP:
            begin
                res = {8'h00, a[3:0], a[7:4]};
                c   = 1'b0;
            end
            OP_SRL:
            begin
                res = {8'h00, 1'b0, a[7:1]};
                c   = a[0];
            end
            OP_BIT:
            begin
                z     = ((a & bit_mask) == 8'h00);
                h     = 1'b1;
                n     = 1'b0;
                valid = 1'b0;
            end
            OP_RES:
                res = {8'h00, a & ~bit_mask};
            OP_SET:
                res = {8'h00, a | bit_mask};
            OP_DAA:
            begin
                // The adjustment runs on a 16-bit intermediate, so a
                // subtraction may wrap past zero; carry is only ever set here.
                dt = {8'h00, a};
                if (n)
                begin
                    if (h)
                    begin
                        dt = dt - DAA_LOW;
                        if (!c)
                            dt = dt & BYTE_MASK;
                    end
                    if (c)
                        dt = dt - DAA_HIGH;
                end
                else
                begin
                    if (h || (dt[3:0] >= DAA_LO_LIM))
                        dt = dt + DAA_LOW;
                    if (c || (dt >= DAA_HI_LIM))
                        dt = dt + DAA_HIGH;
                end
                res = {8'h00, dt[7:0]};
                c   = c | (dt > BYTE_MASK);
                h   = 1'b0;
                z   = (dt[7:0] == 8'h00);
            end
            OP_CPL:
            begin
                res = {8'h00, ~a};
                h   = 1'b1;
                n   = 1'b1;
            end
            OP_SCF:
            begin
                c     = 1'b1;
                h     = 1'b0;
                n     = 1'b0;
                valid = 1'b0;
            end
            OP_CCF:
            begin
                c     = ~c;
                h     = 1'b0;
                n     = 1'b0;
                valid = 1'b0;
            end
            OP_ADD16:
            begin
                wide   = {1'b0, op.operand_a} + {1'b0, op.operand_b};
                twelve = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
                h      = (twelve > {1'b0, HALF16_MASK});
                c      = wide[16];
                n      = 1'b0;
                res    = wide[15:0];
            end
            OP_ADDSP:
            begin
                // The sum uses the sign-extended offset, the flags the
                // unsigned add of the low bytes.
                res  = op.operand_a + {{8{b[7]}}, b};
                nine = {1'b0, op.operand_a[7:0]} + {1'b0, b};
                nib  = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
                c    = nine[8];
                h    = nib[4];
                n    = 1'b0;
                z    = 1'b0;
            end
            OP_INC16:
                res = op.operand_a + 16'h0001;
            OP_DEC16:
                res = op.operand_a - 16'h0001;
            default:
                valid = 1'b0;
        endcase

        // Shifts and rotates share their flag rules; the accumulator forms
        // always clear zero.
        if ((op.operation >= OP_RLC) && (op.operation <= OP_SRL))
        begin
            h = 1'b0;
            n = 1'b0;
            z = (res == 16'h0000);
        end
        else if ((op.operation >= OP_RLCA) && (op.operation <= OP_RRA))
        begin
            h = 1'b0;
            n = 1'b0;
            z = 1'b0;
        end

        r.result       = res;
        r.result_valid = valid;
        r.zero_out     = z;
        r.subtract_out = n;
        r.half_out     = h;
        r.carry_out    = c;
        return r;
    endfunction

    // Operand with a bias towards byte and nibble boundaries.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h00FF;
            3:       return 16'h0FFF;
            4:       return 16'h0080;
            5:       return 16'h000F;
            6:       return 16'h007F;
            default: return 16'($urandom);
        endcase
    endfunction

    // Flags are given as {zero, subtract, half, carry}.
    task automatic queue_op(logic [5:0] code, logic [15:0] a, logic [15:0] b,
                            logic [2:0] bi, logic [3:0] flags);
        alu_in_t item;

        item.operation   = code;
        item.operand_a   = a;
        item.operand_b   = b;
        item.bit_pos     = bi;
        item.zero_in     = flags[3];
        item.subtract_in = flags[2];
        item.half_in     = flags[1];
        item.carry_in    = flags[0];
        queued_ops.push_back(item);
    endtask

    // Stimulus, reset and the end of the run.
    initial
    begin
        logic [5:0] rand_code;

        // Every defined operation once, with the operands and flags cycling
        // through their extremes.
        for (int i = 0; i <= OP_DEC16; i++)
        begin
            case (i % 4)
                0:       queue_op(6'(i), 16'h0000, 16'hFFFF, 3'(i), 4'h0);
                1:       queue_op(6'(i), 16'hFFFF, 16'h0000, 3'(i), 4'hF);
                2:       queue_op(6'(i), 16'h00FF, 16'hFF01, 3'(i), 4'h5);
                default: queue_op(6'(i), 16'h0F80, 16'h0080, 3'(i), 4'hA);
            endcase
        end

        // Carry and borrow at the byte and nibble boundaries.
        queue_op(OP_ADC, 16'h00FF, 16'h0000, 3'd0, 4'h1);
        queue_op(OP_SBC, 16'h0010, 16'h000F, 3'd0, 4'h1);
        // Bit test of a clear bit.
        queue_op(OP_BIT, 16'h00EF, 16'h0000, 3'd4, 4'h0);
        // Decimal adjust after an add that needs both corrections, after a
        // subtraction with half-borrow only, where the intermediate is cut
        // back to a byte, and after one with borrow, where it wraps.
        queue_op(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0);
        queue_op(OP_DAA, 16'h0003, 16'h0000, 3'd0, 4'h6);
        queue_op(OP_DAA, 16'h0005, 16'h0000, 3'd0, 4'h7);
        // Half carry out of bit 11 and full carry out of bit 15.
        queue_op(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h8);
        queue_op(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h0);
        // A negative offset to the stack pointer.
        queue_op(OP_ADDSP, 16'h0000, 16'h0080, 3'd0, 4'hF);
        // Codes with no meaning.
        queue_op(6'd33, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
        queue_op(6'd63, 16'h1234, 16'h5678, 3'd3, 4'h9);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if ($urandom_range(0, 99) < 6)
                rand_code = 6'($urandom_range(33, 63));
            else
                rand_code = 6'($urandom_range(0, OP_DEC16));
            queue_op(rand_code, pick_operand(), pick_operand(),
                     3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        end
        total_ops = queued_ops.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every transaction has been accepted and every outcome
        // returned, then allow a short drain for anything spurious.
        do
            @(posedge clk);
        while ((ops_accepted != total_ops) || (due_results.size() != 0));
        repeat (DRAIN_CYCLES) @(posedge clk);

        if ((failures == 0) && (due_results.size() == 0))
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Operation driver. A transaction is held until it is accepted; between
    // transactions the driver idles at random except during the steady run.
    // The expected outcome is worked out at the edge where the block takes
    // the transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid     <= 1'b0;
            op_data      <= '0;
            ops_accepted <= 0;
        end
        else
        begin
            if (op_valid && op_ready)
            begin
                due_results.push_back(alu_outcome(op_data));
                ops_accepted <= ops_accepted + 1;
            end
            if (!op_valid || op_ready)
            begin
                if ((queued_ops.size() != 0) && (steady || ($urandom_range(0, 99) >= 29)))
                begin
                    op_valid <= 1'b1;
                    op_data  <= queued_ops.pop_front();
                end
                else
                begin
                    op_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each returned transaction is checked field by field
    // against the oldest outstanding outcome; the receiver stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected result transaction: result=%h valid=%b",
                                 res_data.result, res_data.result_valid);
                    failures++;
                end
                else
                begin
                    want_res = due_results.pop_front();
                    if ((res_data.result       !== want_res.result)       ||
                        (res_data.result_valid !== want_res.result_valid) ||
                        (res_data.zero_out     !== want_res.zero_out)     ||
                        (res_data.subtract_out !== want_res.subtract_out) ||
                        (res_data.half_out     !== want_res.half_out)     ||
                        (res_data.carry_out    !== want_res.carry_out))
                    begin
                        if (failures < 10)
                            $display("mismatch: exp %h/%b %b%b%b%b got %h/%b %b%b%b%b",
                                     want_res.result, want_res.result_valid,
                                     want_res.zero_out, want_res.subtract_out,
                                     want_res.half_out, want_res.carry_out,
                                     res_data.result, res_data.result_valid,
                                     res_data.zero_out, res_data.subtract_out,
                                     res_data.half_out, res_data.carry_out);
                        failures++;
                    end
                end
            end
            res_ready <= steady || ($urandom_range(0, 99) >= 29);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
